// ----- sv/nir_pkg.sv -----
// shared types, register codes and compare helpers for the nec infrared frame decoder
// no dependencies
package nir_pkg;

  localparam int TICK_W = 15;
  localparam int US_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam int IDX_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_TOL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TOL   = 3'd5;

  localparam logic [14:0] HDR_MARK_RST  = 15'd9000;
  localparam logic [14:0] HDR_SPACE_RST = 15'd4500;
  localparam logic [9:0]  HDR_TOL_RST   = 10'd200;
  localparam logic [12:0] BIT_MARK_RST  = 13'd560;
  localparam logic [12:0] ONE_SPACE_RST = 13'd1690;
  localparam logic [8:0]  BIT_TOL_RST   = 9'd100;

  localparam logic [IDX_W-1:0] ITEM_SAT    = 6'd33;
  localparam logic [IDX_W-1:0] IDX_ADDR    = 6'd8;
  localparam logic [IDX_W-1:0] IDX_ADDR_INV = 6'd16;
  localparam logic [IDX_W-1:0] IDX_CMD     = 6'd24;
  localparam logic [IDX_W-1:0] IDX_CMD_INV = 6'd32;

  typedef struct packed {
    logic [14:0] hdr_mark;
    logic [14:0] hdr_space;
    logic [9:0]  hdr_tol;
    logic [12:0] bit_mark;
    logic [12:0] one_space;
    logic [8:0]  bit_tol;
  } cfg_t;

  typedef struct packed {
    logic [US_W-1:0] mark_us;
    logic [US_W-1:0] space_us;
    logic            last;
  } item_t;

  // e - t <= d <= e + t, with the lower bound clamped at zero
  function automatic logic in_window(input logic [US_W-1:0] d, input logic [14:0] e,
                                     input logic [9:0] t);
    logic [16:0] dd, ee, tt;
    dd = {1'b0, d};
    ee = {2'b00, e};
    tt = {7'd0, t};
    return ((dd + tt) >= ee) && (dd <= (ee + tt));
  endfunction

  function automatic logic item_match(input logic [US_W-1:0] mark, input logic [US_W-1:0] space,
                                      input logic [14:0] em, input logic [14:0] es,
                                      input logic [9:0] t);
    return in_window(mark, em, t) && ((space == '0) || in_window(space, es, t));
  endfunction

endpackage

// ----- sv/nir_cfg_regs.sv -----
// configuration register file of the nec infrared frame decoder
// depends on nir_pkg
module nir_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [nir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nir_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                         cfg_ready,
  output nir_pkg::cfg_t                cfg
);
  import nir_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr_mark  <= HDR_MARK_RST;
      cfg.hdr_space <= HDR_SPACE_RST;
      cfg.hdr_tol   <= HDR_TOL_RST;
      cfg.bit_mark  <= BIT_MARK_RST;
      cfg.one_space <= ONE_SPACE_RST;
      cfg.bit_tol   <= BIT_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HDR_MARK:  cfg.hdr_mark  <= cfg_data[14:0];
        REG_HDR_SPACE: cfg.hdr_space <= cfg_data[14:0];
        REG_HDR_TOL:   cfg.hdr_tol   <= cfg_data[9:0];
        REG_BIT_MARK:  cfg.bit_mark  <= cfg_data[12:0];
        REG_ONE_SPACE: cfg.one_space <= cfg_data[12:0];
        REG_BIT_TOL:   cfg.bit_tol   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/nir_ingest.sv -----
// input register stage: takes pulse items and converts ticks to microseconds
// depends on nir_pkg
module nir_ingest (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [nir_pkg::TICK_W-1:0]  mark_ticks,
  input  logic [nir_pkg::TICK_W-1:0]  space_ticks,
  input  logic                        last_item,
  output logic                        in_stall,
  input  logic                        res_full,
  input  logic                        res_stall,
  output nir_pkg::item_t              item,
  output logic                        item_fire
);
  import nir_pkg::*;

  logic        item_valid;
  logic        take;
  logic [17:0] mark_x5, space_x5;

  // ticks * 10 / 8 == (ticks * 5) >> 2
  assign mark_x5  = {1'b0, mark_ticks, 2'b00} + {3'b000, mark_ticks};
  assign space_x5 = {1'b0, space_ticks, 2'b00} + {3'b000, space_ticks};

  // only an item that closes a frame needs room in the result register
  assign item_fire = item_valid && (!item.last || !res_full || !res_stall);
  assign in_stall  = item_valid && !item_fire;
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.mark_us  <= mark_x5[17:2];
      item.space_us <= space_x5[17:2];
      item.last     <= last_item;
    end
  end

endmodule

// ----- sv/nir_frame.sv -----
// frame state and result register: header check, bit classing, byte capture
// depends on nir_pkg
module nir_frame (
  input  logic           clk,
  input  logic           rst,
  input  nir_pkg::cfg_t  cfg,
  input  nir_pkg::item_t item,
  input  logic           item_fire,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     command_byte,
  output logic           frame_valid
);
  import nir_pkg::*;

  logic [IDX_W-1:0] item_index, item_index_next;
  logic [2:0]       bit_counter, bit_counter_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic             header_good, header_good_next;
  logic [7:0]       address_byte, address_byte_next;
  logic [7:0]       address_inverse, address_inverse_next;
  logic [7:0]       command_store, command_store_next;
  logic [7:0]       command_inverse, command_inverse_next;
  logic [7:0]       shifted;
  logic             hdr_hit, zero_hit, one_hit, good;

  assign hdr_hit  = item_match(item.mark_us, item.space_us, cfg.hdr_mark, cfg.hdr_space,
                               cfg.hdr_tol);
  assign zero_hit = item_match(item.mark_us, item.space_us, {2'b00, cfg.bit_mark},
                               {2'b00, cfg.bit_mark}, {1'b0, cfg.bit_tol});
  assign one_hit  = item_match(item.mark_us, item.space_us, {2'b00, cfg.bit_mark},
                               {2'b00, cfg.one_space}, {1'b0, cfg.bit_tol});

  always_comb begin
    header_good_next     = header_good;
    address_byte_next    = address_byte;
    address_inverse_next = address_inverse;
    command_store_next   = command_store;
    command_inverse_next = command_inverse;
    bit_counter_next     = bit_counter;
    shift_byte_next      = shift_byte;
    shifted              = shift_byte;

    if (item_index == '0) begin
      header_good_next = hdr_hit;
    end else begin
      // zero class wins when both match
      priority if (zero_hit) begin
        shifted = {1'b0, shift_byte[7:1]};
      end else if (one_hit) begin
        shifted = {1'b1, shift_byte[7:1]};
      end else begin
        // unmatched item shifts nothing
        shifted = shift_byte;
      end
      if (bit_counter == 3'd7) begin
        bit_counter_next = '0;
        shift_byte_next  = '0;
        unique case (item_index)
          IDX_ADDR:     address_byte_next    = shifted;
          IDX_ADDR_INV: address_inverse_next = shifted;
          IDX_CMD:      command_store_next   = shifted;
          IDX_CMD_INV:  command_inverse_next = shifted;
          default: ;
        endcase
      end else begin
        bit_counter_next = bit_counter + 3'd1;
        shift_byte_next  = shifted;
      end
    end

    item_index_next = (item_index < ITEM_SAT) ? item_index + 6'd1 : item_index;

    good = header_good_next
        && (address_byte_next == ~address_inverse_next)
        && (command_store_next == ~command_inverse_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (item_fire && item.last)) begin
      item_index      <= '0;
      bit_counter     <= '0;
      shift_byte      <= '0;
      header_good     <= 1'b0;
      address_byte    <= '0;
      address_inverse <= '0;
      command_store   <= '0;
      command_inverse <= '0;
    end else if (item_fire) begin
      item_index      <= item_index_next;
      bit_counter     <= bit_counter_next;
      shift_byte      <= shift_byte_next;
      header_good     <= header_good_next;
      address_byte    <= address_byte_next;
      address_inverse <= address_inverse_next;
      command_store   <= command_store_next;
      command_inverse <= command_inverse_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_fire && item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.last) begin
      command_byte <= good ? command_store_next : 8'h00;
      frame_valid  <= good;
    end
  end

endmodule

// ----- sv/nec_ir_frame_decoder.sv -----
// top level of the nec infrared frame decoder
// depends on nir_pkg, nir_cfg_regs, nir_ingest, nir_frame
//
//   channel  direction  handshake                fields
//   in       input      in_valid / in_stall      mark_ticks, space_ticks, last_item
//   out      output     out_valid / out_stall    command_byte, frame_valid
//   cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one pulse item per cycle while in_stall is low; an item is registered, then classified and
// folded into the frame state, and the result of a last item is registered from there.
// results appear only for items flagged last_item.
// rst clears the frame state, pipeline valids and loads the default timing registers.
// in_stall rises only while a last item waits behind an unconsumed, stalled result.
module nec_ir_frame_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nir_pkg::TICK_W-1:0]    mark_ticks,
  input  logic [nir_pkg::TICK_W-1:0]    space_ticks,
  input  logic                          last_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    command_byte,
  output logic                          frame_valid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nir_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nir_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_fire;

  nir_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  nir_ingest u_ingest (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .mark_ticks  (mark_ticks),
    .space_ticks (space_ticks),
    .last_item   (last_item),
    .in_stall    (in_stall),
    .res_full    (out_valid),
    .res_stall   (out_stall),
    .item        (item),
    .item_fire   (item_fire)
  );

  nir_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .item_fire    (item_fire),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .command_byte (command_byte),
    .frame_valid  (frame_valid)
  );

endmodule

// ----- sv/nir_checker.sv -----
// port-level checks for the nec infrared frame decoder, bound to the top level
// depends on nir_pkg and nec_ir_frame_decoder
module nir_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [7:0]                    command_byte,
  input logic                          frame_valid,
  input logic                          cfg_ready
);
  import nir_pkg::*;

  // invalid frames always report a zero command
  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> command_byte == 8'h00)
    else $error("invalid frame with nonzero command");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // a result waiting on a stall holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command_byte) && $stable(frame_valid))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind nec_ir_frame_decoder nir_checker u_nir_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .command_byte (command_byte),
  .frame_valid  (frame_valid),
  .cfg_ready    (cfg_ready)
);
